### rtl/core/mcpp_pkg.sv
// shared types and constants for the multichannel peak-to-peak on detector
// no dependencies; the other design files but mcpp_ram refer to it by scoped names, the sim files import it

package mcpp_pkg;

    // default sizing handed to the top level parameters
    localparam int CHANNELS_DEF = 8;
    localparam int ADC_BITS_DEF = 10;

    // fixed field widths of the item, report and threshold
    localparam int OP_W     = 2;
    localparam int PIN_W    = 8;
    localparam int CH_W     = 3;
    localparam int SAMPLE_W = 10;
    localparam int THR_W    = 10;

    // 0.15 V at 5 V over 1024 counts is 30.72, so on means peak-to-peak above 30
    localparam logic [THR_W-1:0] THR_RESET = 10'd30;

    // item operation codes
    localparam logic [OP_W-1:0] OP_REG_PIN = 2'd0;
    localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd1;
    localparam logic [OP_W-1:0] OP_WIN_END = 2'd2;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PIN_RD,
        ST_PIN_CMP,
        ST_PIN_ADD,
        ST_SMP_RD,
        ST_SMP_WR,
        ST_WIN_RD,
        ST_WIN_CMP,
        ST_WIN_FIN
    } state_t;

    // request from the sequencer to the report stage
    typedef struct packed {
        logic            push;
        logic            fin;
        logic [CH_W-1:0] channel;
        logic            on;
    } rpt_req_t;

endpackage

### rtl/core/mcpp_ifs.sv
// valid/ready channel interfaces of the detector: item, report and threshold write
// depends on mcpp_pkg for the field widths

interface mcpp_item_if;
    logic                          valid;
    logic                          ready;
    logic [mcpp_pkg::OP_W-1:0]     op;
    logic [mcpp_pkg::PIN_W-1:0]    pin_number;
    logic [mcpp_pkg::CH_W-1:0]     channel;
    logic [mcpp_pkg::SAMPLE_W-1:0] sample_value;

    modport source (output valid, op, pin_number, channel, sample_value, input ready);
    modport sink   (input valid, op, pin_number, channel, sample_value, output ready);
endinterface

interface mcpp_report_if;
    logic                      valid;
    logic                      ready;
    logic [mcpp_pkg::CH_W-1:0] report_channel;
    logic                      report_on;
    logic                      last_report;

    modport source (output valid, report_channel, report_on, last_report, input ready);
    modport sink   (input valid, report_channel, report_on, last_report, output ready);
endinterface

interface mcpp_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [mcpp_pkg::THR_W-1:0] on_threshold_counts;

    modport source (output valid, on_threshold_counts, input ready);
    modport sink   (input valid, on_threshold_counts, output ready);
endinterface

### rtl/core/mcpp_ram.sv
// generic single-write, single-read synchronous ram with registered read data
// no dependencies

module mcpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/mcpp_report_q.sv
// report stage: one pending change report plus the output register
// the pending slot lets the final report of a window carry last_report
// depends on mcpp_pkg and mcpp_ifs

module mcpp_report_q (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mcpp_pkg::rpt_req_t   req,
    output logic                 ok,
    mcpp_report_if.source        report
);

    localparam int CHW = mcpp_pkg::CH_W;

    logic           pend_valid_reg, pend_valid_next;
    logic [CHW-1:0] pend_ch_reg;
    logic           pend_on_reg;
    logic           out_valid_reg, out_valid_next;
    logic [CHW-1:0] out_ch_reg;
    logic           out_on_reg;
    logic           out_last_reg;
    logic           out_free;
    logic           move;

    // output slot frees when empty or taken this cycle
    assign out_free = !out_valid_reg || report.ready;
    assign ok       = !pend_valid_reg || out_free;
    assign move     = (req.push || req.fin) && pend_valid_reg;

    // next valid flags
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (move)
        begin
            out_valid_next = 1'b1;
        end
        else if (report.ready)
        begin
            out_valid_next = 1'b0;
        end

        pend_valid_next = pend_valid_reg;
        if (req.push)
        begin
            pend_valid_next = 1'b1;
        end
        else if (req.fin)
        begin
            pend_valid_next = 1'b0;
        end
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // payload of the pending slot and the output register
    always_ff @(posedge clk)
    begin
        if (req.push)
        begin
            pend_ch_reg <= req.channel;
            pend_on_reg <= req.on;
        end
        if (move)
        begin
            out_ch_reg   <= pend_ch_reg;
            out_on_reg   <= pend_on_reg;
            out_last_reg <= req.fin;
        end
    end

    assign report.valid          = out_valid_reg;
    assign report.report_channel = out_ch_reg;
    assign report.report_on      = out_on_reg;
    assign report.last_report    = out_last_reg;

`ifndef SYNTHESIS
    a_req_when_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (req.push || req.fin) |-> ok)
        else $error("report request while report stage is full");

    a_fin_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        (req.fin && pend_valid_reg) |=> (out_valid_reg && out_last_reg && !pend_valid_reg))
        else $error("window end did not release the pending report as last");

    a_push_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (req.push && pend_valid_reg) |=> (out_valid_reg && !out_last_reg && pend_valid_reg))
        else $error("pending report moved out with wrong last flag");
`endif

endmodule

### rtl/core/mcpp_seq.sv
// item sequencer: pin search and insert, sample read-modify-write, window-end scan
// drives the pin table ram and the window ram; depends on mcpp_pkg and mcpp_ifs

module mcpp_seq #(
    parameter int CHANNELS = mcpp_pkg::CHANNELS_DEF,
    parameter int ADC_BITS = mcpp_pkg::ADC_BITS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    mcpp_item_if.sink                                     item,
    input  logic [mcpp_pkg::THR_W-1:0]                    thr,
    input  logic                                          rpt_ok,
    output mcpp_pkg::rpt_req_t                            rpt_req,
    // pin table ram
    output logic                                          pin_we,
    output logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] pin_waddr,
    output logic [mcpp_pkg::PIN_W-1:0]                    pin_wdata,
    output logic                                          pin_re,
    output logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] pin_raddr,
    input  logic [mcpp_pkg::PIN_W-1:0]                    pin_rdata,
    // window ram, {minimum, maximum}
    output logic                                          win_we,
    output logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] win_waddr,
    output logic [2*ADC_BITS:0]                           win_wdata,
    output logic                                          win_re,
    output logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] win_raddr,
    input  logic [2*ADC_BITS:0]                           win_rdata
);

    localparam int AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CW   = $clog2(CHANNELS + 1);
    localparam int CHW  = mcpp_pkg::CH_W;
    localparam int PW   = mcpp_pkg::PIN_W;
    localparam int TW   = mcpp_pkg::THR_W;
    localparam int MW   = ADC_BITS + 1;
    localparam int KW   = (CW > CHW) ? CW : CHW;
    localparam int EW   = (MW > TW) ? MW : TW;
    localparam logic [MW-1:0] FULL_SCALE = MW'(1) << ADC_BITS;

    mcpp_pkg::state_t state_reg, state_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [PW-1:0]       pin_reg, pin_next;
    logic [AW-1:0]       ch_reg, ch_next;
    logic [ADC_BITS-1:0] sample_reg, sample_next;
    logic [CHANNELS-1:0] on_state_reg, on_state_next;
    logic [CHANNELS-1:0] win_valid_reg, win_valid_next;

    logic                accept;
    logic                idx_last;
    logic [MW-1:0]       cur_min;
    logic [ADC_BITS-1:0] cur_max;
    logic [MW-1:0]       new_min;
    logic [ADC_BITS-1:0] new_max;
    logic [MW-1:0]       p2p;
    logic                now_on;
    logic                changed;

    assign accept   = item.valid && item.ready;
    assign idx_last = ((CW'(idx_reg) + CW'(1)) == count_reg);

    // window entry as stored, or restarted when not written since the last restart
    always_comb
    begin
        if (win_valid_reg[win_raddr])
        begin
            cur_min = win_rdata[2*ADC_BITS:ADC_BITS];
            cur_max = win_rdata[ADC_BITS-1:0];
        end
        else
        begin
            cur_min = FULL_SCALE;
            cur_max = '0;
        end
    end

    // sample update of the running extremes
    always_comb
    begin
        new_max = (sample_reg > cur_max) ? sample_reg : cur_max;
        new_min = ({1'b0, sample_reg} < cur_min) ? {1'b0, sample_reg} : cur_min;
    end

    // peak-to-peak against threshold
    always_comb
    begin
        p2p     = {1'b0, cur_max} - cur_min;
        now_on  = ({1'b0, cur_max} > cur_min) && (EW'(p2p) > EW'(thr));
        changed = (now_on != on_state_reg[idx_reg]);
    end

    // next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        pin_next       = pin_reg;
        ch_next        = ch_reg;
        sample_next    = sample_reg;
        on_state_next  = on_state_reg;
        win_valid_next = win_valid_reg;

        item.ready = 1'b0;

        pin_we    = 1'b0;
        pin_waddr = AW'(count_reg);
        pin_wdata = pin_reg;
        pin_re    = 1'b0;
        pin_raddr = idx_reg;

        win_we    = 1'b0;
        win_waddr = ch_reg;
        win_wdata = {new_min, new_max};
        win_re    = 1'b0;
        win_raddr = (state_reg == mcpp_pkg::ST_SMP_WR || state_reg == mcpp_pkg::ST_SMP_RD)
                    ? ch_reg : idx_reg;

        rpt_req.push    = 1'b0;
        rpt_req.fin     = 1'b0;
        rpt_req.channel = CHW'(idx_reg);
        rpt_req.on      = now_on;

        case (state_reg)
            mcpp_pkg::ST_IDLE:
            begin
                item.ready = 1'b1;
                if (accept)
                begin
                    pin_next    = item.pin_number;
                    ch_next     = AW'(item.channel);
                    sample_next = ADC_BITS'(item.sample_value);
                    idx_next    = '0;
                    case (item.op)
                        mcpp_pkg::OP_REG_PIN:
                        begin
                            if (count_reg == CW'(CHANNELS))
                            begin
                                state_next = mcpp_pkg::ST_IDLE;
                            end
                            else if (count_reg == '0)
                            begin
                                state_next = mcpp_pkg::ST_PIN_ADD;
                            end
                            else
                            begin
                                state_next = mcpp_pkg::ST_PIN_RD;
                            end
                        end
                        mcpp_pkg::OP_SAMPLE:
                        begin
                            if (KW'(item.channel) < KW'(count_reg))
                            begin
                                state_next = mcpp_pkg::ST_SMP_RD;
                            end
                        end
                        mcpp_pkg::OP_WIN_END:
                        begin
                            if (count_reg == '0)
                            begin
                                win_valid_next = '0;
                            end
                            else
                            begin
                                state_next = mcpp_pkg::ST_WIN_RD;
                            end
                        end
                        default:
                        begin
                            state_next = mcpp_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            // linear search over the listed pins
            mcpp_pkg::ST_PIN_RD:
            begin
                pin_re     = 1'b1;
                state_next = mcpp_pkg::ST_PIN_CMP;
            end

            mcpp_pkg::ST_PIN_CMP:
            begin
                if (pin_rdata == pin_reg)
                begin
                    state_next = mcpp_pkg::ST_IDLE;
                end
                else if (idx_last)
                begin
                    state_next = mcpp_pkg::ST_PIN_ADD;
                end
                else
                begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = mcpp_pkg::ST_PIN_RD;
                end
            end

            // append a new channel with a fresh window and off state
            mcpp_pkg::ST_PIN_ADD:
            begin
                pin_we                        = 1'b1;
                on_state_next[AW'(count_reg)]  = 1'b0;
                win_valid_next[AW'(count_reg)] = 1'b0;
                count_next                    = count_reg + CW'(1);
                state_next                    = mcpp_pkg::ST_IDLE;
            end

            // sample read-modify-write
            mcpp_pkg::ST_SMP_RD:
            begin
                win_re     = 1'b1;
                state_next = mcpp_pkg::ST_SMP_WR;
            end

            mcpp_pkg::ST_SMP_WR:
            begin
                win_we                 = 1'b1;
                win_valid_next[ch_reg] = 1'b1;
                state_next             = mcpp_pkg::ST_IDLE;
            end

            // window-end scan over listed channels
            mcpp_pkg::ST_WIN_RD:
            begin
                win_re     = 1'b1;
                state_next = mcpp_pkg::ST_WIN_CMP;
            end

            mcpp_pkg::ST_WIN_CMP:
            begin
                if (!changed || rpt_ok)
                begin
                    rpt_req.push           = changed;
                    on_state_next[idx_reg] = now_on;
                    if (idx_last)
                    begin
                        state_next = mcpp_pkg::ST_WIN_FIN;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = mcpp_pkg::ST_WIN_RD;
                    end
                end
            end

            // release the final report, if any, and restart every window
            mcpp_pkg::ST_WIN_FIN:
            begin
                if (rpt_ok)
                begin
                    rpt_req.fin    = 1'b1;
                    win_valid_next = '0;
                    state_next     = mcpp_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = mcpp_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mcpp_pkg::ST_IDLE;
            idx_reg       <= '0;
            count_reg     <= '0;
            on_state_reg  <= '0;
            win_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            on_state_reg  <= on_state_next;
            win_valid_reg <= win_valid_next;
        end
    end

    // item payload held during processing
    always_ff @(posedge clk)
    begin
        pin_reg    <= pin_next;
        ch_reg     <= ch_next;
        sample_reg <= sample_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CHANNELS))
        else $error("channel count beyond table size");

    a_push_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_req.push |-> (state_reg == mcpp_pkg::ST_WIN_CMP && idx_reg < AW'(count_reg - CW'(1))
                          || state_reg == mcpp_pkg::ST_WIN_CMP && idx_last))
        else $error("change report outside the window scan");

    a_fin_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_req.fin |=> (win_valid_reg == '0 && state_reg == mcpp_pkg::ST_IDLE))
        else $error("window end did not restart the windows");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mcpp_pkg::ST_WIN_CMP && changed && !rpt_ok)
        |=> (state_reg == mcpp_pkg::ST_WIN_CMP && $stable(idx_reg) && $stable(on_state_reg)))
        else $error("scan advanced while report stage was full");
`endif

endmodule

### rtl/core/multichannel_peak_to_peak_on_detector.sv
// Peak-to-peak on/off detector for up to CHANNELS current-sensor channels. A register
// item (op 0) appends a pin to the channel table unless listed or full; a sample item
// (op 1) updates that channel's running minimum and maximum; a window-end item (op 2)
// reports, in channel order, each channel whose on state changed (peak-to-peak above
// the threshold counts) and restarts all windows, last_report marking the final report.
// One item is processed at a time by a sequencer around two memories with one write and
// one read port each (pin table, window extremes): a listed channel's sample is read,
// written back, an ignored item is dropped while idle, a register item searches the
// listed pins, and a window end reads the listed channels, waiting on report stalls.
// The next item is taken while a report still waits in the output register. No memory
// clearing pass follows reset: per-channel valid flags stand in for restarted windows.
// depends on mcpp_pkg, mcpp_ifs, mcpp_ram, mcpp_seq and mcpp_report_q

module multichannel_peak_to_peak_on_detector #(
    parameter int CHANNELS = mcpp_pkg::CHANNELS_DEF,
    parameter int ADC_BITS = mcpp_pkg::ADC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    mcpp_item_if.sink     item,
    mcpp_report_if.source report,
    mcpp_cfg_if.sink      cfg
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PW = mcpp_pkg::PIN_W;
    localparam int TW = mcpp_pkg::THR_W;
    localparam int WW = 2 * ADC_BITS + 1;

    logic [TW-1:0]       thr_reg, thr_next;
    logic                rpt_ok;
    mcpp_pkg::rpt_req_t  rpt_req;

    logic                pin_we, pin_re;
    logic [AW-1:0]       pin_waddr, pin_raddr;
    logic [PW-1:0]       pin_wdata, pin_rdata;
    logic                win_we, win_re;
    logic [AW-1:0]       win_waddr, win_raddr;
    logic [WW-1:0]       win_wdata, win_rdata;

    // threshold register, always writable
    assign cfg.ready = 1'b1;
    assign thr_next  = (cfg.valid && cfg.ready) ? cfg.on_threshold_counts : thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= mcpp_pkg::THR_RESET;
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    // pin table
    mcpp_ram #(
        .WIDTH (PW),
        .DEPTH (CHANNELS)
    ) u_pin_ram (
        .clk   (clk),
        .we    (pin_we),
        .waddr (pin_waddr),
        .wdata (pin_wdata),
        .re    (pin_re),
        .raddr (pin_raddr),
        .rdata (pin_rdata)
    );

    // window extremes
    mcpp_ram #(
        .WIDTH (WW),
        .DEPTH (CHANNELS)
    ) u_win_ram (
        .clk   (clk),
        .we    (win_we),
        .waddr (win_waddr),
        .wdata (win_wdata),
        .re    (win_re),
        .raddr (win_raddr),
        .rdata (win_rdata)
    );

    // item sequencer
    mcpp_seq #(
        .CHANNELS (CHANNELS),
        .ADC_BITS (ADC_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .thr       (thr_reg),
        .rpt_ok    (rpt_ok),
        .rpt_req   (rpt_req),
        .pin_we    (pin_we),
        .pin_waddr (pin_waddr),
        .pin_wdata (pin_wdata),
        .pin_re    (pin_re),
        .pin_raddr (pin_raddr),
        .pin_rdata (pin_rdata),
        .win_we    (win_we),
        .win_waddr (win_waddr),
        .win_wdata (win_wdata),
        .win_re    (win_re),
        .win_raddr (win_raddr),
        .win_rdata (win_rdata)
    );

    // report output stage
    mcpp_report_q u_report_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (rpt_req),
        .ok     (rpt_ok),
        .report (report)
    );

endmodule

### sim/mcpp_onoff_checker.sv
// on/off change checker: watches the item, report and threshold channels of the detector,
// keeps its own channel table and window extremes and compares every report beat
// depends on mcpp_pkg and mcpp_ifs

module mcpp_onoff_checker (
    input  logic   clk,
    input  logic   rst_n,
    mcpp_item_if   item,
    mcpp_report_if report,
    mcpp_cfg_if    cfg,
    output int     errors,
    output int     pending
);
    import mcpp_pkg::*;

    localparam int N_CH  = CHANNELS_DEF;
    localparam int ADC_W = ADC_BITS_DEF;
    localparam logic [ADC_W:0] MIN_RESTART = {1'b1, {ADC_W{1'b0}}};

    typedef struct packed {
        logic [CH_W-1:0] channel;
        logic            on;
        logic            last;
    } change_t;

    // expected change reports, oldest first
    change_t expected_changes [$];

    // mirrored block state
    logic [PIN_W-1:0] pin_list [N_CH];
    int               listed_count;
    logic [ADC_W:0]   win_lo [N_CH];
    logic [ADC_W-1:0] win_hi [N_CH];
    logic             on_now [N_CH];
    logic [THR_W-1:0] threshold;

    function void restart_window(int c);
        win_lo[c] = MIN_RESTART;
        win_hi[c] = '0;
    endfunction

    // append a pin unless listed or the table is full
    function void add_pin(logic [PIN_W-1:0] pin);
        bit seen;
        seen = 1'b0;
        for (int i = 0; i < listed_count; i++)
            if (pin_list[i] == pin)
                seen = 1'b1;
        if (listed_count < N_CH && !seen)
        begin
            pin_list[listed_count] = pin;
            on_now[listed_count]   = 1'b0;
            restart_window(listed_count);
            listed_count++;
        end
    endfunction

    // running extremes, unregistered channels ignored
    function void take_sample(logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] val);
        if (int'(ch) < listed_count)
        begin
            if (val > win_hi[ch])
                win_hi[ch] = val;
            if ({1'b0, val} < win_lo[ch])
                win_lo[ch] = {1'b0, val};
        end
    endfunction

    // compare peak-to-peak with the threshold, queue state changes in channel order
    function void close_window();
        change_t chg;
        int      first_new;
        logic    now_on;
        first_new = expected_changes.size();
        for (int i = 0; i < listed_count; i++)
        begin
            now_on = (win_hi[i] > win_lo[i]) &&
                     (int'(win_hi[i]) - int'(win_lo[i]) > int'(threshold));
            if (now_on != on_now[i])
            begin
                on_now[i]   = now_on;
                chg.channel = CH_W'(i);
                chg.on      = now_on;
                chg.last    = 1'b0;
                expected_changes.push_back(chg);
            end
        end
        if (expected_changes.size() > first_new)
            expected_changes[expected_changes.size() - 1].last = 1'b1;
        for (int i = 0; i < N_CH; i++)
            restart_window(i);
    endfunction

    // track beats on all three channels
    always @(posedge clk or negedge rst_n)
    begin
        change_t want;
        if (!rst_n)
        begin
            threshold    = THR_RESET;
            listed_count = 0;
            errors       = 0;
            for (int i = 0; i < N_CH; i++)
            begin
                pin_list[i] = '0;
                on_now[i]   = 1'b0;
                restart_window(i);
            end
            expected_changes.delete();
        end
        else
        begin
            // report beat against the oldest expectation
            if (report.valid && report.ready)
            begin
                if (expected_changes.size() == 0)
                begin
                    errors++;
                    $error("unexpected report beat: channel %0d on %0d last %0d",
                           report.report_channel, report.report_on, report.last_report);
                end
                else
                begin
                    want = expected_changes.pop_front();
                    if (report.report_channel !== want.channel)
                    begin
                        errors++;
                        $error("report_channel: expected %0d, actual %0d",
                               want.channel, report.report_channel);
                    end
                    if (report.report_on !== want.on)
                    begin
                        errors++;
                        $error("report_on: expected %0d, actual %0d",
                               want.on, report.report_on);
                    end
                    if (report.last_report !== want.last)
                    begin
                        errors++;
                        $error("last_report: expected %0d, actual %0d",
                               want.last, report.last_report);
                    end
                end
            end
            // threshold write
            if (cfg.valid && cfg.ready)
                threshold = cfg.on_threshold_counts;
            // item beat
            if (item.valid && item.ready)
            begin
                case (item.op)
                    OP_REG_PIN: add_pin(item.pin_number);
                    OP_SAMPLE:  take_sample(item.channel, item.sample_value);
                    OP_WIN_END: close_window();
                    default:    ;
                endcase
            end
        end
        pending = expected_changes.size();
    end

endmodule

### sim/testbench.sv
// top of the detector test: clock, reset, item and threshold stimulus, report backpressure
// and the verdict; checking is done by mcpp_onoff_checker
// depends on mcpp_pkg, mcpp_ifs, the detector and the checker

module testbench;
    import mcpp_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 42;
    localparam int PHASES         = 5;
    localparam int MAX_CH         = CHANNELS_DEF;
    localparam int SAMPLE_MAX     = (1 << SAMPLE_W) - 1;

    logic             clk = 1'b0;
    logic             rst_n;
    int               mismatches;
    int               outstanding;
    int               idle_cycles;
    int               ready_hold;
    int               useful_items;
    bit               steady_feed;
    logic [THR_W-1:0] thr_now;
    logic [PIN_W-1:0] pins_sent [$];
    int               base_lvl [MAX_CH];
    int               swing [MAX_CH];

    mcpp_item_if   item_bus ();
    mcpp_report_if report_bus ();
    mcpp_cfg_if    cfg_bus ();

    multichannel_peak_to_peak_on_detector i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .report (report_bus),
        .cfg    (cfg_bus)
    );

    mcpp_onoff_checker i_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_bus),
        .report  (report_bus),
        .cfg     (cfg_bus),
        .errors  (mismatches),
        .pending (outstanding)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // report backpressure: short stalls, a few long ones, long stretches without any
    always @(negedge clk)
    begin
        int r;
        if (ready_hold > 0)
            ready_hold--;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                report_bus.ready = 1'b1;
                ready_hold = $urandom_range(0, 7);
            end
            else if (r < 70)
            begin
                report_bus.ready = 1'b1;
                ready_hold = $urandom_range(30, 80);
            end
            else if (r < 92)
            begin
                report_bus.ready = 1'b0;
                ready_hold = $urandom_range(0, 2);
            end
            else
            begin
                report_bus.ready = 1'b0;
                ready_hold = $urandom_range(10, 40);
            end
        end
    end

    // cycles without any beat
    always @(posedge clk)
    begin
        if ((item_bus.valid && item_bus.ready) || (report_bus.valid && report_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // watchdog
    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // sender gap: mostly none or short, a few long
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_feed || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // one item beat, driven at the falling edge
    task send_item(logic [OP_W-1:0] op, int pin, int ch, int val);
        int gap;
        item_bus.op           = op;
        item_bus.pin_number   = PIN_W'(pin);
        item_bus.channel      = CH_W'(ch);
        item_bus.sample_value = SAMPLE_W'(val);
        item_bus.valid        = 1'b1;
        do
            @(posedge clk);
        while (!item_bus.ready);
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            item_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task register_pin(int pin);
        bit seen;
        seen = 1'b0;
        send_item(OP_REG_PIN, pin, $urandom_range(0, 7), $urandom_range(0, SAMPLE_MAX));
        foreach (pins_sent[i])
            if (pins_sent[i] == PIN_W'(pin))
                seen = 1'b1;
        if (!seen && pins_sent.size() < MAX_CH)
        begin
            pins_sent.push_back(PIN_W'(pin));
            useful_items++;
        end
    endtask

    task sample(int ch, int val);
        send_item(OP_SAMPLE, $urandom_range(0, 255), ch, val);
    endtask

    task end_window();
        send_item(OP_WIN_END, $urandom_range(0, 255), $urandom_range(0, 7),
                  $urandom_range(0, SAMPLE_MAX));
    endtask

    // wait until all reports are out and the block has gone quiet
    task settle();
        item_bus.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task write_threshold(int val);
        settle();
        cfg_bus.on_threshold_counts = THR_W'(val);
        cfg_bus.valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        @(negedge clk);
        cfg_bus.valid = 1'b0;
        thr_now = THR_W'(val);
    endtask

    // per-channel swing around the current threshold so states toggle often
    task shape_window();
        for (int c = 0; c < MAX_CH; c++)
        begin
            case ($urandom_range(0, 5))
                0: swing[c] = 0;
                1: swing[c] = (thr_now > 0) ? int'(thr_now) - 1 : 0;
                2: swing[c] = int'(thr_now);
                3: swing[c] = (int'(thr_now) < SAMPLE_MAX) ? int'(thr_now) + 1 : SAMPLE_MAX;
                default: swing[c] = $urandom_range(0, SAMPLE_MAX);
            endcase
            base_lvl[c] = $urandom_range(0, SAMPLE_MAX - swing[c]);
        end
    endtask

    function int level(int c);
        case ($urandom_range(0, 2))
            0: return base_lvl[c];
            1: return base_lvl[c] + swing[c];
            default: return base_lvl[c] + $urandom_range(0, swing[c]);
        endcase
    endfunction

    // samples for listed channels then, mostly, a window end, with some noise mixed in
    task random_window();
        int n;
        int r;
        int c;
        shape_window();
        steady_feed = ($urandom_range(0, 3) == 0);
        n = $urandom_range(0, 14);
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
                register_pin($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 255));
            else if (r < 9)
                send_item(OP_UNUSED, $urandom_range(0, 255), $urandom_range(0, 7),
                          $urandom_range(0, SAMPLE_MAX));
            else if (r < 14 || pins_sent.size() == 0)
                sample($urandom_range(0, 7), $urandom_range(0, SAMPLE_MAX));
            else
            begin
                c = $urandom_range(0, pins_sent.size() - 1);
                sample(c, level(c));
                useful_items++;
            end
        end
        // now and then a window is left open and runs into the next one
        if ($urandom_range(0, 19) != 0)
        begin
            end_window();
            useful_items++;
        end
        // now and then the sender holds off until every report is out
        if ($urandom_range(0, 9) == 0)
            settle();
    endtask

    // stimulus
    initial
    begin
        rst_n                       = 1'b0;
        item_bus.valid              = 1'b0;
        item_bus.op                 = OP_REG_PIN;
        item_bus.pin_number         = '0;
        item_bus.channel            = '0;
        item_bus.sample_value       = '0;
        cfg_bus.valid               = 1'b0;
        cfg_bus.on_threshold_counts = '0;
        thr_now                     = THR_RESET;
        steady_feed                 = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // window end with an empty table
        end_window();
        // registration, duplicate pin
        register_pin(0);
        register_pin(255);
        register_pin(0);
        // full-scale swing on channel 0, swing exactly at threshold on channel 1
        sample(0, 0);
        sample(0, SAMPLE_MAX);
        sample(1, 500);
        sample(1, 500 + THR_RESET);
        // sample for an unregistered channel, unknown op
        sample(7, SAMPLE_MAX);
        send_item(OP_UNUSED, 255, 7, SAMPLE_MAX);
        end_window();
        // channel 0 without samples goes off, channel 1 one count above threshold
        sample(1, 500);
        sample(1, 501 + THR_RESET);
        end_window();
        // single sample, no swing
        sample(0, 700);
        end_window();

        // random phases over several thresholds
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: ;
                1: write_threshold(0);
                2: write_threshold(SAMPLE_MAX);
                3: write_threshold($urandom_range(1, SAMPLE_MAX - 1));
                default: write_threshold(THR_RESET);
            endcase
            useful_items = 0;
            while (useful_items < PHASE_ITEMS)
                random_window();
        end

        settle();
        if (mismatches == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/core/mcpp_pkg.sv
rtl/core/mcpp_ifs.sv
rtl/core/mcpp_ram.sv
rtl/core/mcpp_report_q.sv
rtl/core/mcpp_seq.sv
rtl/core/multichannel_peak_to_peak_on_detector.sv
sim/mcpp_onoff_checker.sv
sim/testbench.sv
